// File: rtl/lsh_pkg.sv
// Shared types and constants of the set and slice histogram.
package lsh_pkg;

  localparam int unsigned ADDR_W   = 46;
  localparam int unsigned SEL_W    = 11;
  localparam int unsigned SLICE_W  = 3;
  localparam int unsigned SLICES   = 8;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned LINE_OFS = 6;
  localparam int unsigned DIV_W    = ADDR_W - LINE_OFS;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_MASK_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_MASK_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_MASK_HIGH = 2'd2;

  localparam logic [ADDR_W-1:0] MASK_LOW_RST  = 46'h1B5F575440;
  localparam logic [ADDR_W-1:0] MASK_MID_RST  = 46'h2EB5FAA880;
  localparam logic [ADDR_W-1:0] MASK_HIGH_RST = 46'h3CCCC93100;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef logic [SLICES-1:0][COUNT_W-1:0] count_row_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

endpackage

// File: rtl/lsh_if.sv
// Handshake channels of the histogram: address samples in, results out.
interface lsh_in_if import lsh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [ADDR_W-1:0]   phys_addr;
  logic [SEL_W-1:0]    set_select;

  modport source (output valid, output operation, output phys_addr, output set_select,
                  input ready);
  modport sink   (input valid, input operation, input phys_addr, input set_select,
                  output ready);
endinterface

interface lsh_out_if import lsh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLICE_W-1:0]  slice_number;
  logic [SEL_W-1:0]    set_number;
  logic [COUNT_W-1:0]  count_slice0;
  logic [COUNT_W-1:0]  count_slice1;
  logic [COUNT_W-1:0]  count_slice2;
  logic [COUNT_W-1:0]  count_slice3;
  logic [COUNT_W-1:0]  count_slice4;
  logic [COUNT_W-1:0]  count_slice5;
  logic [COUNT_W-1:0]  count_slice6;
  logic [COUNT_W-1:0]  count_slice7;

  modport source (output valid, output slice_number, output set_number,
                  output count_slice0, output count_slice1, output count_slice2,
                  output count_slice3, output count_slice4, output count_slice5,
                  output count_slice6, output count_slice7, input ready);
  modport sink   (input valid, input slice_number, input set_number,
                  input count_slice0, input count_slice1, input count_slice2,
                  input count_slice3, input count_slice4, input count_slice5,
                  input count_slice6, input count_slice7, output ready);
endinterface

// File: rtl/lsh_fifo.sv
// Two-entry queue between the classifying front end and the counter back end.
module lsh_fifo #(
  parameter int unsigned WIDTH = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/lsh_front.sv
// Front end: mask registers, slice hash and set index of each incoming beat.
module lsh_front import lsh_pkg::*; #(
  parameter int unsigned SET_COUNT = 2048,
  parameter int unsigned ADDR_BITS = 46,
  parameter int unsigned SET_W     = $clog2(SET_COUNT),
  parameter int unsigned ENTRY_W   = SET_W + SLICE_W + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lsh_in_if.sink               in_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 clearing,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [ENTRY_W-1:0]   q_data
);

  localparam int unsigned EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (EFF_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << EFF_BITS) - ADDR_W'(1));
  localparam int unsigned SELX_W = (SET_W > SEL_W) ? SET_W : SEL_W;
  localparam int unsigned DIGITS = (DIV_W + 7) / 8;
  localparam int unsigned PAD_W  = DIGITS * 8;
  localparam int unsigned SUM_W  = SET_W + 3;

  typedef logic [DIGITS-1:0][255:0][SET_W-1:0] digit_tbl_t;

  // Entry [i][d] holds d * 256**i reduced modulo SET_COUNT.
  function automatic digit_tbl_t digit_table();
    digit_tbl_t      t;
    longint unsigned w;
    t = '0;
    w = 64'd1;
    for (int i = 0; i < DIGITS; i++) begin
      for (int d = 0; d < 256; d++) begin
        t[i][d] = SET_W'((longint'(d) * w) % SET_COUNT);
      end
      w = (w << 8) % SET_COUNT;
    end
    return t;
  endfunction

  logic [ADDR_W-1:0]  mask_low_r, mask_mid_r, mask_high_r;
  logic [ADDR_W-1:0]  addr_eff;
  logic [SLICE_W-1:0] slice_hash;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_low_r  <= MASK_LOW_RST;
      mask_mid_r  <= MASK_MID_RST;
      mask_high_r <= MASK_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLICE_MASK_LOW:  mask_low_r  <= cfg_wdata;
        REG_SLICE_MASK_MID:  mask_mid_r  <= cfg_wdata;
        REG_SLICE_MASK_HIGH: mask_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Each slice bit is the parity of the address under its own mask.
  always_comb begin
    addr_eff      = in_ch.phys_addr & ADDR_MASK;
    slice_hash[0] = ^(addr_eff & mask_low_r);
    slice_hash[1] = ^(addr_eff & mask_mid_r);
    slice_hash[2] = ^(addr_eff & mask_high_r);
  end

  if ((1 << SET_W) == SET_COUNT) begin : g_pow2
    logic [SELX_W-1:0] sel_ext;
    logic [SET_W-1:0]  set_idx;

    always_comb begin
      sel_ext = SELX_W'(in_ch.set_select);
      set_idx = (in_ch.operation == OP_READ) ? sel_ext[SET_W-1:0]
                                             : addr_eff[LINE_OFS +: SET_W];
    end

    assign in_ch.ready = q_ready && !clearing;
    assign q_valid     = in_ch.valid && !clearing;
    assign q_data      = {in_ch.operation, slice_hash, set_idx};
  end else begin : g_serial
    // The residue of each dividend byte comes from a constant table. Their sum
    // stays below eight times SET_COUNT, so three compare-and-subtract steps
    // bring it into range.
    localparam digit_tbl_t DIGIT_TBL = digit_table();
    localparam logic [SUM_W-1:0] M1 = SUM_W'(SET_COUNT);
    localparam logic [SUM_W-1:0] M2 = SUM_W'(2 * SET_COUNT);
    localparam logic [SUM_W-1:0] M4 = SUM_W'(4 * SET_COUNT);

    front_state_t        state_r, state_nxt;
    logic [SUM_W-1:0]    sum_r;
    logic [SET_W-1:0]    rem_r;
    logic                op_r;
    logic [SLICE_W-1:0]  slice_r;
    logic [PAD_W-1:0]    dividend;
    logic [SUM_W-1:0]    sum_nxt;
    logic [SUM_W-1:0]    red4, red2, red1;
    logic                accept;

    assign in_ch.ready = (state_r == F_IDLE) && !clearing;
    assign accept      = in_ch.valid && in_ch.ready;
    assign q_valid     = (state_r == F_PUSH);
    assign q_data      = {op_r, slice_r, rem_r};

    always_comb begin
      dividend = (in_ch.operation == OP_READ) ? PAD_W'(in_ch.set_select)
                                              : PAD_W'(addr_eff[ADDR_W-1:LINE_OFS]);
      sum_nxt = '0;
      for (int i = 0; i < DIGITS; i++) begin
        sum_nxt = sum_nxt + SUM_W'(DIGIT_TBL[i][dividend[8*i +: 8]]);
      end
      red4 = (sum_r >= M4) ? sum_r - M4 : sum_r;
      red2 = (red4 >= M2) ? red4 - M2 : red4;
      red1 = (red2 >= M1) ? red2 - M1 : red2;
    end

    always_comb begin
      state_nxt = state_r;
      case (state_r)
        F_IDLE:  if (accept) state_nxt = F_DIV;
        F_DIV:   state_nxt = F_PUSH;
        F_PUSH:  if (q_ready) state_nxt = F_IDLE;
        default: state_nxt = F_IDLE;
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        state_r <= F_IDLE;
      end else begin
        state_r <= state_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        sum_r   <= sum_nxt;
        op_r    <= in_ch.operation;
        slice_r <= slice_hash;
      end else if (state_r == F_DIV) begin
        rem_r <= red1[SET_W-1:0];
      end
    end
  end

endmodule

// File: rtl/lsh_back.sv
// Back end: counter memory, read-modify-write stage and result register.
module lsh_back import lsh_pkg::*; #(
  parameter int unsigned SET_COUNT = 2048,
  parameter int unsigned SET_W     = $clog2(SET_COUNT),
  parameter int unsigned ENTRY_W   = SET_W + SLICE_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               clearing,
  lsh_out_if.source          out_ch
);

  localparam int unsigned SETX_W = (SET_W > SEL_W) ? SET_W : SEL_W;

  logic [COUNT_W-1:0] cnt_mem_r [SLICES][SET_COUNT];

  logic               clr_busy_r;
  logic [SET_W-1:0]   clr_addr_r;

  logic               s1_valid_r;
  logic               s1_op_r;
  logic [SLICE_W-1:0] s1_slice_r;
  logic [SET_W-1:0]   s1_set_r;
  count_row_t         rd_row_r;

  logic               fwd_valid_r;
  logic [SET_W-1:0]   fwd_set_r;
  count_row_t         fwd_row_r;

  logic               out_valid_r;
  logic [SLICE_W-1:0] out_slice_r;
  logic [SEL_W-1:0]   out_set_r;
  count_row_t         out_row_r;

  logic               s1_adv, pop;
  logic               q_op;
  logic [SLICE_W-1:0] q_slice;
  logic [SET_W-1:0]   q_set;
  count_row_t         cur_row, new_row;
  logic [SETX_W-1:0]  set_ext;

  assign {q_op, q_slice, q_set} = q_data;
  assign clearing = clr_busy_r;
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign pop      = q_valid && !clr_busy_r && (!s1_valid_r || s1_adv);
  assign q_ready  = pop;

  // The last row written is the newest copy of that set, whichever cycle it came from.
  always_comb begin
    cur_row = (fwd_valid_r && (fwd_set_r == s1_set_r)) ? fwd_row_r : rd_row_r;
    new_row = '0;
    if (s1_op_r == OP_RECORD) begin
      new_row = cur_row;
      if (cur_row[s1_slice_r] != COUNT_MAX) begin
        new_row[s1_slice_r] = cur_row[s1_slice_r] + COUNT_W'(1);
      end
    end
    set_ext = SETX_W'(s1_set_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + SET_W'(1);
        if (clr_addr_r == SET_W'(SET_COUNT - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        fwd_valid_r <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      for (int k = 0; k < SLICES; k++) begin
        cnt_mem_r[k][clr_addr_r] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < SLICES; k++) begin
        cnt_mem_r[k][s1_set_r] <= new_row[k];
      end
    end
    if (pop) begin
      for (int k = 0; k < SLICES; k++) begin
        rd_row_r[k] <= cnt_mem_r[k][q_set];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r    <= q_op;
      s1_slice_r <= q_slice;
      s1_set_r   <= q_set;
    end
    if (s1_adv) begin
      fwd_set_r   <= s1_set_r;
      fwd_row_r   <= new_row;
      out_slice_r <= (s1_op_r == OP_READ) ? '0 : s1_slice_r;
      out_set_r   <= set_ext[SEL_W-1:0];
      out_row_r   <= (s1_op_r == OP_READ) ? cur_row : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slice_number = out_slice_r;
  assign out_ch.set_number   = out_set_r;
  assign out_ch.count_slice0 = out_row_r[0];
  assign out_ch.count_slice1 = out_row_r[1];
  assign out_ch.count_slice2 = out_row_r[2];
  assign out_ch.count_slice3 = out_row_r[3];
  assign out_ch.count_slice4 = out_row_r[4];
  assign out_ch.count_slice5 = out_row_r[5];
  assign out_ch.count_slice6 = out_row_r[6];
  assign out_ch.count_slice7 = out_row_r[7];

endmodule

// File: rtl/llc_slice_set_histogram.sv
// Top level of the set and slice histogram of sampled physical addresses.
//
//   channel  direction  beat contents
//   in_ch    sink       operation, phys_addr, set_select
//   out_ch   source     slice_number, set_number, count_slice0..7
//   cfg_*    write      slice_mask_low / _mid / _high by index
//
// With a power-of-two SET_COUNT one beat is taken per cycle while the queue has
// room; a result passes the queue, then the counter read-modify-write, which is
// one stage, then the result register. Otherwise the set index is reduced through
// per-byte residue tables in the front end, which takes no new beat until it has
// pushed the last one into the queue after its division and push states.
// After reset a clearing pass zeroes the counter memory, one set per cycle, through
// all SET_COUNT sets; no beat is taken meanwhile.
// A stalled output holds its result while the queue goes on filling.
module llc_slice_set_histogram import lsh_pkg::*; #(
  parameter int unsigned SET_COUNT = 2048,
  parameter int unsigned ADDR_BITS = 46
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lsh_in_if.sink               in_ch,
  lsh_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  localparam int unsigned SET_W   = $clog2(SET_COUNT);
  localparam int unsigned ENTRY_W = SET_W + SLICE_W + 1;

  logic               clearing;
  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  lsh_front #(
    .SET_COUNT (SET_COUNT),
    .ADDR_BITS (ADDR_BITS),
    .SET_W     (SET_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_valid   (push_valid),
    .q_ready   (push_ready),
    .q_data    (push_data)
  );

  lsh_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lsh_back #(
    .SET_COUNT (SET_COUNT),
    .SET_W     (SET_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_data   (pop_data),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
